### design/hcs_pkg.sv
package hcs_pkg;

    localparam int EXT_W   = 19;
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 16;
    localparam int MUL_W   = 19;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int Y_W     = 18;

    localparam logic [EXT_W-1:0] MAX_EXTENSION = 19'd355736;
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [15:0] Q14_ONE = 16'd16384;

    // register indexes
    localparam logic [2:0] CFG_CENTER     = 3'd0;
    localparam logic [2:0] CFG_PILOT_LAG  = 3'd1;
    localparam logic [2:0] CFG_MAIN_LAG   = 3'd2;
    localparam logic [2:0] CFG_CRACK      = 3'd3;
    localparam logic [2:0] CFG_FULL       = 3'd4;
    localparam logic [2:0] CFG_EXT_STEP   = 3'd5;
    localparam logic [2:0] CFG_RET_STEP   = 3'd6;
    localparam logic [2:0] CFG_INIT_EXT   = 3'd7;

    localparam logic [14:0] PFRAC_TAB [6] = '{
        15'd0, 15'd6554, 15'd8192, 15'd9830, 15'd13107, 15'd16384
    };
    localparam logic signed [Y_W-1:0] PPRES_TAB [6] = '{
        18'sd0, 18'sd7680, 18'sd12800, 18'sd16640, 18'sd28800, 18'sd40960
    };

    localparam logic [EXT_W-1:0] EXT_TAB [18] = '{
        19'd0, 19'd3992, 19'd27617, 19'd60079, 19'd94202, 19'd135586,
        19'd173626, 19'd212610, 19'd237107, 19'd242727, 19'd264375,
        19'd268549, 19'd303743, 19'd306447, 19'd312013, 19'd320742,
        19'd328562, 19'd355736
    };
    localparam logic signed [Y_W-1:0] ANGLE_TAB [18] = '{
        -18'sd8545, -18'sd8412, -18'sd7634, -18'sd6554, -18'sd5404,
        -18'sd3981, -18'sd2639, -18'sd1219, -18'sd294, 18'sd79, 18'sd763,
        18'sd929, 18'sd2365, 18'sd2481, 18'sd2716, 18'sd3092, 18'sd3436,
        18'sd4677
    };

    typedef struct packed {
        logic signed [Y_W-1:0] y0;
        logic [15:0]           dx;
        logic [15:0]           dy;
        logic [15:0]           span;
    } t_seg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    function automatic t_seg pilot_seg(input logic [14:0] x);
        t_seg       s;
        logic [2:0] sel;
        logic [2:0] lo;
        sel = 3'd5;
        for (int i = 5; i >= 1; i--) begin
            if (x <= PFRAC_TAB[i]) sel = 3'(i);
        end
        lo = sel - 3'd1;
        s.dx = '0;
        s.dy = '0;
        s.span = 16'd1;
        if (x == '0) begin
            s.y0 = PPRES_TAB[0];
        end else if (x >= PFRAC_TAB[5]) begin
            s.y0 = PPRES_TAB[5];
        end else begin
            s.y0 = PPRES_TAB[lo];
            s.dx = 16'(x - PFRAC_TAB[lo]);
            s.dy = 16'(PPRES_TAB[sel] - PPRES_TAB[lo]);
            s.span = 16'(PFRAC_TAB[sel] - PFRAC_TAB[lo]);
        end
        return s;
    endfunction

    function automatic t_seg ext_seg(input logic [EXT_W-1:0] x);
        t_seg       s;
        logic [4:0] sel;
        logic [4:0] lo;
        sel = 5'd17;
        for (int i = 17; i >= 1; i--) begin
            if (x <= EXT_TAB[i]) sel = 5'(i);
        end
        lo = sel - 5'd1;
        s.dx = '0;
        s.dy = '0;
        s.span = 16'd1;
        if (x == '0) begin
            s.y0 = ANGLE_TAB[0];
        end else if (x >= EXT_TAB[17]) begin
            s.y0 = ANGLE_TAB[17];
        end else begin
            s.y0 = ANGLE_TAB[lo];
            s.dx = 16'(x - EXT_TAB[lo]);
            s.dy = 16'(ANGLE_TAB[sel] - ANGLE_TAB[lo]);
            s.span = 16'(EXT_TAB[sel] - EXT_TAB[lo]);
        end
        return s;
    endfunction

    // divide by 2^k, nearest, halves away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] p, input int k);
        logic [PROD_W-1:0] mag;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        mag = (mag + (PROD_W'(1) << (k - 1))) >> k;
        return p[PROD_W-1] ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic logic [EXT_W-1:0] ext_clamp(input logic signed [EXT_W+1:0] e);
        if (e < 0) return '0;
        if (e > signed'({2'b00, MAX_EXTENSION})) return MAX_EXTENSION;
        return e[EXT_W-1:0];
    endfunction

endpackage

### design/hcs_div.sv
module hcs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcs_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [hcs_pkg::NUM_W-1:0]     o_quo
);

    logic                        r_busy;
    logic                        r_done;
    logic [4:0]                  r_cnt;
    logic [hcs_pkg::DEN_W:0]     r_rem;
    logic [hcs_pkg::NUM_W-1:0]   r_quo;
    logic [hcs_pkg::DEN_W-1:0]   r_den;
    logic [hcs_pkg::DEN_W:0]     rem_sh;
    logic                        fits;

    // restoring, one quotient bit a cycle
    assign rem_sh = {r_rem[hcs_pkg::DEN_W-1:0], r_quo[hcs_pkg::NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[hcs_pkg::NUM_W-2:0], fits};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### design/hcs_mul.sv
module hcs_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hcs_pkg::MUL_W-1:0]    i_a,
    input  logic signed [hcs_pkg::MUL_W-1:0]    i_b,
    output logic signed [hcs_pkg::PROD_W-1:0]   o_p
);

    logic signed [hcs_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### design/pilot_hydraulic_cylinder_step.sv
// channel   direction  handshake                 word
// input     in         i_in_valid / o_in_stall   i_pwm_command
// result    out        o_out_valid / i_out_stall o_target_pressure .. o_blade_angle
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one tick makes four passes of the shared divider (pwm fraction, pilot table, flow
// ramp, angle table), with the multiplier and update states between them; the result
// is loaded into the output registers in S_DONE.
// o_in_stall is high from acceptance until the result is loaded and while a config
// word is offered; config is taken only while idle. a new word is taken while the
// previous result still waits under i_out_stall.
// synchronous active-low reset loads register defaults and the initial extension.
module pilot_hydraulic_cylinder_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_pwm_command,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [16:0] o_target_pressure,
    output logic signed [16:0] o_pilot_pressure,
    output logic signed [15:0] o_flow_fraction,
    output logic signed [16:0] o_extension_delta,
    output logic [18:0]        o_extension,
    output logic signed [14:0] o_blade_angle,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [18:0]        i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FDIV  = 5'd1;
    localparam logic [4:0] S_PMUL  = 5'd2;
    localparam logic [4:0] S_PDIVS = 5'd3;
    localparam logic [4:0] S_PDIV  = 5'd4;
    localparam logic [4:0] S_LAG1  = 5'd5;
    localparam logic [4:0] S_LAG1W = 5'd6;
    localparam logic [4:0] S_FLS   = 5'd7;
    localparam logic [4:0] S_FLDIV = 5'd8;
    localparam logic [4:0] S_LAG2  = 5'd9;
    localparam logic [4:0] S_LAG2W = 5'd10;
    localparam logic [4:0] S_DMUL  = 5'd11;
    localparam logic [4:0] S_DMULW = 5'd12;
    localparam logic [4:0] S_EXT   = 5'd13;
    localparam logic [4:0] S_ASEG  = 5'd14;
    localparam logic [4:0] S_AMUL  = 5'd15;
    localparam logic [4:0] S_ADIVS = 5'd16;
    localparam logic [4:0] S_ADIV  = 5'd17;
    localparam logic [4:0] S_DONE  = 5'd18;

    logic [4:0]  r_state, n_state;

    logic [7:0]  r_center;
    logic [16:0] r_alpha_p, r_alpha_m;
    logic [15:0] r_crack, r_full, r_ext_step, r_ret_step;

    logic               r_neg, r_fz, r_ff, r_fneg;
    hcs_pkg::t_seg      r_seg;
    logic signed [16:0] r_target, r_pstate, r_delta;
    logic signed [15:0] r_ftarget, r_fstate;
    logic [18:0]        r_ext;
    logic signed [14:0] r_angle;

    logic               r_out_valid;
    logic signed [16:0] r_o_target, r_o_pilot, r_o_delta;
    logic signed [15:0] r_o_flow;
    logic [18:0]        r_o_ext;
    logic signed [14:0] r_o_angle;

    hcs_pkg::t_div_req  div_req;
    logic               div_done;
    logic [31:0]        div_quo;
    logic               mul_en;
    logic signed [18:0] mul_a, mul_b;
    logic signed [37:0] mul_p;

    logic               in_acc;
    logic [7:0]         pd, fden;
    logic [16:0]        pmag;
    logic               fz, ff;
    logic [15:0]        flden;
    logic [16:0]        alpha_p, alpha_m;
    logic [15:0]        ft_mag;
    logic signed [17:0] t_mag;
    logic signed [20:0] ext_sum;
    logic [18:0]        ext_next;

    hcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    hcs_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    // a pending config word goes first
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    assign alpha_p = (r_alpha_p > hcs_pkg::Q16_ONE) ? hcs_pkg::Q16_ONE : r_alpha_p;
    assign alpha_m = (r_alpha_m > hcs_pkg::Q16_ONE) ? hcs_pkg::Q16_ONE : r_alpha_m;

    always_comb begin
        // pwm fraction operands
        if (i_pwm_command > r_center) begin
            pd   = i_pwm_command - r_center;
            fden = 8'd255 - r_center;
        end else if (i_pwm_command < r_center) begin
            pd   = r_center - i_pwm_command;
            fden = r_center;
        end else begin
            pd   = '0;
            fden = 8'd1;
        end
        // flow ramp operands
        pmag  = r_pstate[16] ? 17'(-r_pstate) : 17'(r_pstate);
        fz    = pmag <= {1'b0, r_crack};
        ff    = r_full <= r_crack;
        flden = r_full - r_crack;
        ft_mag = r_fz ? 16'd0 :
                 r_ff ? hcs_pkg::Q14_ONE :
                 (div_quo > 32'(hcs_pkg::Q14_ONE)) ? hcs_pkg::Q14_ONE : div_quo[15:0];
        t_mag  = 18'(r_seg.y0 + signed'({2'b00, div_quo[15:0]}));
        ext_sum  = signed'({2'b00, r_ext}) + 21'(r_delta);
        ext_next = hcs_pkg::ext_clamp(ext_sum);

        div_req = '0;
        div_req.den = 16'd1;
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state) inside
            S_IDLE: begin
                div_req.start = in_acc;
                div_req.num   = 32'({pd, 14'b0}) + 32'(fden >> 1);
                div_req.den   = 16'(fden);
            end
            S_PMUL, S_AMUL: begin
                mul_en = 1'b1;
                mul_a  = signed'({3'b000, r_seg.dx});
                mul_b  = signed'({3'b000, r_seg.dy});
            end
            S_PDIVS, S_ADIVS: begin
                div_req.start = 1'b1;
                div_req.num   = mul_p[31:0] + 32'(r_seg.span >> 1);
                div_req.den   = r_seg.span;
            end
            S_LAG1: begin
                mul_en = 1'b1;
                mul_a  = signed'({2'b00, alpha_p});
                mul_b  = 19'(r_target) - 19'(r_pstate);
            end
            S_FLS: begin
                div_req.start = 1'b1;
                if (!(fz || ff)) begin
                    div_req.num = (32'(17'(pmag - {1'b0, r_crack})) << 14)
                                  + 32'(flden >> 1);
                    div_req.den = flden;
                end
            end
            S_LAG2: begin
                mul_en = 1'b1;
                mul_a  = signed'({2'b00, alpha_m});
                mul_b  = 19'(r_ftarget) - 19'(r_fstate);
            end
            S_DMUL: begin
                mul_en = 1'b1;
                mul_a  = 19'(r_fstate);
                mul_b  = signed'({3'b000, r_fstate[15] ? r_ret_step : r_ext_step});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_FDIV;
            S_FDIV:  if (div_done) n_state = S_PMUL;
            S_PMUL:  n_state = S_PDIVS;
            S_PDIVS: n_state = S_PDIV;
            S_PDIV:  if (div_done) n_state = S_LAG1;
            S_LAG1:  n_state = S_LAG1W;
            S_LAG1W: n_state = S_FLS;
            S_FLS:   n_state = S_FLDIV;
            S_FLDIV: if (div_done) n_state = S_LAG2;
            S_LAG2:  n_state = S_LAG2W;
            S_LAG2W: n_state = S_DMUL;
            S_DMUL:  n_state = S_DMULW;
            S_DMULW: n_state = S_EXT;
            S_EXT:   n_state = S_ASEG;
            S_ASEG:  n_state = S_AMUL;
            S_AMUL:  n_state = S_ADIVS;
            S_ADIVS: n_state = S_ADIV;
            S_ADIV:  if (div_done) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_center    <= 8'd127;
            r_alpha_p   <= 17'd16384;
            r_alpha_m   <= 17'd16384;
            r_crack     <= 16'd6400;
            r_full      <= 16'd32000;
            r_ext_step  <= 16'd512;
            r_ret_step  <= 16'd512;
            r_ext       <= hcs_pkg::ext_clamp(21'sd241534);
            r_pstate    <= '0;
            r_fstate    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    hcs_pkg::CFG_CENTER:    r_center   <= i_cfg_data[7:0];
                    hcs_pkg::CFG_PILOT_LAG: r_alpha_p  <= i_cfg_data[16:0];
                    hcs_pkg::CFG_MAIN_LAG:  r_alpha_m  <= i_cfg_data[16:0];
                    hcs_pkg::CFG_CRACK:     r_crack    <= i_cfg_data[15:0];
                    hcs_pkg::CFG_FULL:      r_full     <= i_cfg_data[15:0];
                    hcs_pkg::CFG_EXT_STEP:  r_ext_step <= i_cfg_data[15:0];
                    hcs_pkg::CFG_RET_STEP:  r_ret_step <= i_cfg_data[15:0];
                    hcs_pkg::CFG_INIT_EXT: begin
                        r_ext <= hcs_pkg::ext_clamp(signed'({2'b00, i_cfg_data}));
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE:  if (in_acc) r_neg <= i_pwm_command < r_center;
                S_FDIV:  if (div_done) r_seg <= hcs_pkg::pilot_seg(div_quo[14:0]);
                S_PDIV:  if (div_done) r_target <= r_neg ? 17'(-t_mag) : 17'(t_mag);
                S_LAG1W: r_pstate <= 17'(38'(r_pstate) + hcs_pkg::rnd_shift(mul_p, 16));
                S_FLS: begin
                    r_fz   <= fz;
                    r_ff   <= ff;
                    r_fneg <= r_pstate[16];
                end
                S_FLDIV: if (div_done) begin
                    r_ftarget <= r_fneg ? -signed'(ft_mag) : signed'(ft_mag);
                end
                S_LAG2W: r_fstate <= 16'(38'(r_fstate) + hcs_pkg::rnd_shift(mul_p, 16));
                S_DMULW: r_delta <= 17'(hcs_pkg::rnd_shift(mul_p, 14));
                S_EXT: begin
                    r_ext <= ext_next;
                    // held at a stop and pushing further into it
                    if (ext_next == r_ext &&
                        ((ext_next == '0 && r_delta < 0) ||
                         (ext_next == hcs_pkg::MAX_EXTENSION && r_delta > 0)))
                        r_delta <= '0;
                end
                S_ASEG:  r_seg <= hcs_pkg::ext_seg(r_ext);
                S_ADIV:  if (div_done) r_angle <= 15'(t_mag);
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_target  <= r_target;
                        r_o_pilot   <= r_pstate;
                        r_o_flow    <= r_fstate;
                        r_o_delta   <= r_delta;
                        r_o_ext     <= r_ext;
                        r_o_angle   <= r_angle;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_target_pressure = r_o_target;
    assign o_pilot_pressure  = r_o_pilot;
    assign o_flow_fraction   = r_o_flow;
    assign o_extension_delta = r_o_delta;
    assign o_extension       = r_o_ext;
    assign o_blade_angle     = r_o_angle;

endmodule
